FILE: rtl/cpfd_pkg.sv
package cpfd_pkg;

    localparam int HDR_BYTES = 12;
    localparam logic [11:0] MIN_FRAME_BYTES = 12'd13;
    localparam logic [11:0] MAX_FRAME_BYTES = 12'd2048;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
    localparam logic [7:0]  MAGIC0   = 8'h51;
    localparam logic [7:0]  MAGIC1   = 8'h4B;
    localparam logic [8:0]  PN_SEED  = 9'h1FF;

    // result queue geometry
    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = 3;
    localparam int OQ_CW    = 4;

    // register map, indexed by paddr[2]
    localparam logic REG_FRAME_LEN = 1'b0;
    localparam logic REG_WHITEN    = 1'b1;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_LEN_BIG   = 2'd2;
    localparam logic [1:0] ST_CRC_BAD   = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [10:0] payload_len;
        logic [31:0] sequence_res;
        logic [1:0]  status;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [11:0] frame_len;
        logic        whiten_en;
    } cfg_t;

    // up to two results per byte, res0 always first
    typedef struct packed {
        logic [1:0] num;
        res_t       res0;
        res_t       res1;
    } push_t;

    // eight steps of x^9+x^5+1, msb first: {next state, pn byte}
    function automatic logic [16:0] pn9_step8(input logic [8:0] seed);
        logic [8:0] s;
        logic [7:0] b;
        logic       nb;
        s = seed;
        b = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            nb = s[8] ^ s[4];
            s  = {s[7:0], nb};
            b  = {b[6:0], nb};
        end
        return {s, b};
    endfunction

    // reflected crc-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] d);
        logic [31:0] c;
        c = crc ^ {24'h000000, d};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/cpfd_if.sv
interface cpfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface cpfd_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [10:0] payload_len;
    logic [31:0] sequence_res;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, output kind, output data_byte, output payload_len,
                    output sequence_res, output status, output last, input ready);
    modport sink (input valid, input kind, input data_byte, input payload_len,
                  input sequence_res, input status, input last, output ready);
endinterface

FILE: rtl/cpfd_core.sv
module cpfd_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    cpfd_in_if.sink                       in_ch,
    input  cpfd_pkg::cfg_t                cfg,
    input  logic [cpfd_pkg::OQ_CW-1:0]    oq_count,
    output cpfd_pkg::push_t               push
);

    // input word register
    logic       stage_valid_reg;
    logic [7:0] stage_byte_reg;
    logic       stage_start_reg;

    // frame parse state
    logic [10:0] pos_reg,    pos_next;
    logic [8:0]  lfsr_reg,   lfsr_next;
    logic [31:0] crc_reg,    crc_next;
    logic [15:0] len_reg,    len_next;
    logic [31:0] seq_reg,    seq_next;
    logic [31:0] rcrc_reg,   rcrc_next;
    logic        magic_reg,  magic_next;
    logic        inf_reg,    inf_next;

    logic [10:0] pos_b;
    logic [8:0]  lfsr_b;
    logic [31:0] crc_b;
    logic [15:0] len_b;
    logic [31:0] seq_b;
    logic [31:0] rcrc_b;
    logic        magic_b;
    logic        inf_b;

    logic [16:0] pn_out;
    logic [7:0]  b;
    logic        act;
    logic [11:0] flen;
    logic [11:0] maxpay;
    logic        len_ok;
    logic        pay;
    logic        done;
    logic [10:0] pay_idx;
    logic [1:0]  st;
    logic [4:0]  space_need;
    cpfd_pkg::res_t data_res;
    cpfd_pkg::res_t verd_res;

    // room for this word's results plus whatever the staged word may push
    assign space_need  = {1'b0, oq_count} + (stage_valid_reg ? 5'd2 : 5'd0);
    assign in_ch.ready = (space_need <= 5'(cpfd_pkg::OQ_DEPTH - 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= in_ch.valid && in_ch.ready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            stage_byte_reg  <= in_ch.rx_byte;
            stage_start_reg <= in_ch.frame_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 11'd0;
            lfsr_reg  <= cpfd_pkg::PN_SEED;
            crc_reg   <= cpfd_pkg::CRC_ONES;
            len_reg   <= 16'd0;
            seq_reg   <= 32'd0;
            rcrc_reg  <= 32'd0;
            magic_reg <= 1'b0;
            inf_reg   <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            lfsr_reg  <= lfsr_next;
            crc_reg   <= crc_next;
            len_reg   <= len_next;
            seq_reg   <= seq_next;
            rcrc_reg  <= rcrc_next;
            magic_reg <= magic_next;
            inf_reg   <= inf_next;
        end
    end

    // clamp the frame length
    always_comb
    begin
        if (cfg.frame_len < cpfd_pkg::MIN_FRAME_BYTES)
        begin
            flen = cpfd_pkg::MIN_FRAME_BYTES;
        end
        else if (cfg.frame_len > cpfd_pkg::MAX_FRAME_BYTES)
        begin
            flen = cpfd_pkg::MAX_FRAME_BYTES;
        end
        else
        begin
            flen = cfg.frame_len;
        end
    end

    assign maxpay = flen - 12'(cpfd_pkg::HDR_BYTES);

    always_comb
    begin
        // frame start restarts everything
        if (stage_start_reg)
        begin
            pos_b   = 11'd0;
            lfsr_b  = cpfd_pkg::PN_SEED;
            crc_b   = cpfd_pkg::CRC_ONES;
            len_b   = 16'd0;
            seq_b   = 32'd0;
            rcrc_b  = 32'd0;
            magic_b = 1'b0;
            inf_b   = 1'b1;
        end
        else
        begin
            pos_b   = pos_reg;
            lfsr_b  = lfsr_reg;
            crc_b   = crc_reg;
            len_b   = len_reg;
            seq_b   = seq_reg;
            rcrc_b  = rcrc_reg;
            magic_b = magic_reg;
            inf_b   = inf_reg;
        end

        act    = stage_valid_reg && inf_b;
        pn_out = cpfd_pkg::pn9_step8(lfsr_b);
        b      = stage_byte_reg ^ (cfg.whiten_en ? pn_out[7:0] : 8'h00);

        len_next   = len_b;
        seq_next   = seq_b;
        rcrc_next  = rcrc_b;
        magic_next = magic_b;
        case (pos_b)
            11'd0:   magic_next = (b == cpfd_pkg::MAGIC0);
            11'd1:   magic_next = magic_b && (b == cpfd_pkg::MAGIC1);
            11'd2:   len_next[7:0]    = b;
            11'd3:   len_next[15:8]   = b;
            11'd4:   seq_next[7:0]    = b;
            11'd5:   seq_next[15:8]   = b;
            11'd6:   seq_next[23:16]  = b;
            11'd7:   seq_next[31:24]  = b;
            11'd8:   rcrc_next[7:0]   = b;
            11'd9:   rcrc_next[15:8]  = b;
            11'd10:  rcrc_next[23:16] = b;
            11'd11:  rcrc_next[31:24] = b;
            default: len_next = len_b;
        endcase

        len_ok  = len_next <= {4'h0, maxpay};
        pay_idx = pos_b - 11'(cpfd_pkg::HDR_BYTES);
        pay     = (pos_b >= 11'(cpfd_pkg::HDR_BYTES)) && len_ok
                  && ({5'd0, pay_idx} < len_next);

        // crc bytes of the header count as zero
        crc_next = crc_b;
        if (pos_b < 11'(cpfd_pkg::HDR_BYTES))
        begin
            crc_next = cpfd_pkg::crc32_byte(crc_b, (pos_b >= 11'd8) ? 8'h00 : b);
        end
        else if (pay)
        begin
            crc_next = cpfd_pkg::crc32_byte(crc_b, b);
        end

        done = ({1'b0, pos_b} + 12'd1) >= flen;

        if (!magic_next)
        begin
            st = cpfd_pkg::ST_BAD_MAGIC;
        end
        else if (!len_ok)
        begin
            st = cpfd_pkg::ST_LEN_BIG;
        end
        else if ((crc_next ^ cpfd_pkg::CRC_ONES) != rcrc_next)
        begin
            st = cpfd_pkg::ST_CRC_BAD;
        end
        else
        begin
            st = cpfd_pkg::ST_OK;
        end

        data_res              = '0;
        data_res.kind         = cpfd_pkg::KIND_DATA;
        data_res.data_byte    = b;

        verd_res              = '0;
        verd_res.kind         = cpfd_pkg::KIND_VERDICT;
        verd_res.payload_len  = (st == cpfd_pkg::ST_BAD_MAGIC || st == cpfd_pkg::ST_LEN_BIG)
                                ? 11'd0 : len_next[10:0];
        verd_res.sequence_res = seq_next;
        verd_res.status       = st;
        verd_res.last         = 1'b1;

        if (done)
        begin
            pos_next = 11'd0;
            inf_next = 1'b0;
        end
        else
        begin
            pos_next = pos_b + 11'd1;
            inf_next = inf_b;
        end
        lfsr_next = pn_out[16:8];

        push.num  = 2'd0;
        push.res0 = pay ? data_res : verd_res;
        push.res1 = verd_res;

        if (act)
        begin
            push.num = {1'b0, pay} + {1'b0, done};
        end
        else
        begin
            // idle or stray byte outside a frame: hold state
            pos_next   = pos_reg;
            lfsr_next  = lfsr_reg;
            crc_next   = crc_reg;
            len_next   = len_reg;
            seq_next   = seq_reg;
            rcrc_next  = rcrc_reg;
            magic_next = magic_reg;
            inf_next   = inf_reg;
        end
    end

endmodule

FILE: rtl/cpfd_oq.sv
module cpfd_oq
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cpfd_pkg::push_t               push,
    output logic [cpfd_pkg::OQ_CW-1:0]    count,
    cpfd_out_if.source                    out_ch
);

    cpfd_pkg::res_t                   mem_reg [cpfd_pkg::OQ_DEPTH];
    logic [cpfd_pkg::OQ_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [cpfd_pkg::OQ_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [cpfd_pkg::OQ_CW-1:0]       count_reg,  count_next;
    logic                             pop;
    logic [cpfd_pkg::OQ_AW-1:0]       wr_ptr_p1;
    cpfd_pkg::res_t                   head;

    assign count     = count_reg;
    assign pop       = out_ch.valid && out_ch.ready;
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;
    assign head      = mem_reg[rd_ptr_reg];

    assign out_ch.valid        = (count_reg != '0);
    assign out_ch.kind         = head.kind;
    assign out_ch.data_byte    = head.data_byte;
    assign out_ch.payload_len  = head.payload_len;
    assign out_ch.sequence_res = head.sequence_res;
    assign out_ch.status       = head.status;
    assign out_ch.last         = head.last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + cpfd_pkg::OQ_AW'(push.num);
        rd_ptr_next = rd_ptr_reg + cpfd_pkg::OQ_AW'(pop);
        count_next  = count_reg + cpfd_pkg::OQ_CW'(push.num) - cpfd_pkg::OQ_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.num == 2'd2)
        begin
            mem_reg[wr_ptr_p1] <= push.res1;
        end
    end

endmodule

FILE: rtl/crc_pn9_frame_decoder.sv
// path: an accepted word is held in the input word register, its results are then
//   written into the result queue, which drives the output
// throughput: one word per cycle; input stalls while the queue lacks room for the
//   staged word's and the next word's results; a last byte can give two results
// reset: rst_n asynchronous, active low; clears parse state, queue and registers
//   (frame_length 1516, whiten_enable 0); no clearing pass
module crc_pn9_frame_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    cpfd_in_if.sink     in_ch,
    cpfd_out_if.source  out_ch
);

    // configuration registers
    logic [11:0] frame_len_reg;
    logic        whiten_en_reg;
    logic        cfg_wr;

    cpfd_pkg::cfg_t              cfg;
    cpfd_pkg::push_t             push;
    logic [cpfd_pkg::OQ_CW-1:0]  oq_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // register index is paddr[2]; the low address bits are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_len_reg <= 12'd1516;
            whiten_en_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                cpfd_pkg::REG_FRAME_LEN: frame_len_reg <= pwdata[11:0];
                cpfd_pkg::REG_WHITEN:    whiten_en_reg <= pwdata[0];
                default:                 frame_len_reg <= frame_len_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            cpfd_pkg::REG_FRAME_LEN: prdata = {20'd0, frame_len_reg};
            cpfd_pkg::REG_WHITEN:    prdata = {31'd0, whiten_en_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    assign cfg.frame_len = frame_len_reg;
    assign cfg.whiten_en = whiten_en_reg;

    // parse: input word register, dewhitening, header fields, crc, verdict
    cpfd_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .cfg      (cfg),
        .oq_count (oq_count),
        .push     (push)
    );

    // result queue: up to two results in a cycle, one out a cycle while ready
    cpfd_oq u_oq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .count  (oq_count),
        .out_ch (out_ch)
    );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

    import cpfd_pkg::*;

    // flaws that the frame builder can put into an otherwise good frame
    typedef enum logic [1:0] {
        FLAW_NONE,
        FLAW_MAGIC,
        FLAW_CRC
    } frame_flaw_t;

    localparam int          CLK_HIGH_NS   = 10;
    localparam int          CLK_LOW_NS    = 10;
    localparam int          RESET_CYCLES  = 8;
    // time for the block to go quiet, with plenty of margin on top
    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_LIMIT   = 20000;
    localparam int unsigned RANDOM_WORDS  = 1100;
    localparam longint      TIMEOUT_NS    = 20_000_000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cpfd_in_if  in_ch ();
    cpfd_out_if out_ch ();

    crc_pn9_frame_decoder u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    always
    begin
        clk = 1'b1;
        #(CLK_HIGH_NS);
        clk = 1'b0;
        #(CLK_LOW_NS);
    end

    // ------------------------------------------------------------------
    // shared state between the stimulus, the deframer model and the checker
    // ------------------------------------------------------------------
    int   errors;
    bit   src_gaps;      // random idle bursts on the sending side
    bit   sink_stalls;   // random stall bursts on the receiving side
    bit   hold_req;      // asks the receiver for one long hold-off

    // shadow of the configuration registers
    logic [11:0] cfg_frame_len;
    logic        cfg_whiten;

    // model copy of the parse state
    logic [10:0] mdl_pos;
    logic [8:0]  mdl_lfsr;
    logic [31:0] mdl_crc;
    logic [15:0] mdl_len;
    logic [31:0] mdl_seq;
    logic [31:0] mdl_rx_crc;
    bit          mdl_magic_ok;
    bit          mdl_in_frame;

    // results still owed by the block, oldest first
    res_t exp_q [$];

    // frame under construction, already whitened where the shadow says so
    logic [7:0]  frame_buf [0:2047];
    int unsigned frame_n;

    // ------------------------------------------------------------------
    // arithmetic of the deframer
    // ------------------------------------------------------------------

    // reflected crc-32 over one byte, lsb first
    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] d);
        logic [31:0] c;
        c = crc ^ {24'd0, d};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    // eight steps of the pn9 generator, msb first: {next state, pn byte}
    function automatic logic [16:0] pn9_advance(input logic [8:0] s);
        logic [8:0] st;
        logic [7:0] pn;
        logic       fb;
        st = s;
        pn = 8'd0;
        for (int k = 0; k < 8; k++)
        begin
            fb = st[8] ^ st[4];
            st = {st[7:0], fb};
            pn = {pn[6:0], fb};
        end
        return {st, pn};
    endfunction

    // the register value clamped to what the block can frame
    function automatic int unsigned frame_bytes(input logic [11:0] f);
        if (f < MIN_FRAME_BYTES)
            return MIN_FRAME_BYTES;
        if (f > MAX_FRAME_BYTES)
            return MAX_FRAME_BYTES;
        return f;
    endfunction

    // ------------------------------------------------------------------
    // deframer model: one accepted word in, zero to two expected results out
    // ------------------------------------------------------------------
    task automatic predict_word(input logic [7:0] rx, input logic sof);
        logic [7:0]  b;
        logic [16:0] pn;
        int unsigned flen;
        int unsigned maxpay;
        int unsigned pos;
        bit          len_ok;
        res_t        r;
        flen   = frame_bytes(cfg_frame_len);
        maxpay = flen - HDR_BYTES;

        // a start always wins, even in mid-frame: the old frame just vanishes
        if (sof)
        begin
            mdl_pos      = '0;
            mdl_lfsr     = PN_SEED;
            mdl_crc      = CRC_ONES;
            mdl_len      = '0;
            mdl_seq      = '0;
            mdl_rx_crc   = '0;
            mdl_magic_ok = 1'b0;
            mdl_in_frame = 1'b1;
        end
        // bytes between frames are dropped without a trace
        if (!mdl_in_frame)
            return;

        pos      = mdl_pos;
        // the generator runs on every frame byte, the enable only gates the xor
        pn       = pn9_advance(mdl_lfsr);
        mdl_lfsr = pn[16:8];
        b        = cfg_whiten ? (rx ^ pn[7:0]) : rx;

        if (pos == 0)
            mdl_magic_ok = (b == MAGIC0);
        else if (pos == 1)
            mdl_magic_ok = mdl_magic_ok && (b == MAGIC1);
        else if (pos < 4)
            mdl_len[8*(pos-2) +: 8] = b;
        else if (pos < 8)
            mdl_seq[8*(pos-4) +: 8] = b;
        else if (pos < HDR_BYTES)
            mdl_rx_crc[8*(pos-8) +: 8] = b;

        len_ok = (mdl_len <= maxpay);
        if (pos < HDR_BYTES)
        begin
            // the crc field itself counts as zeros
            mdl_crc = crc_update(mdl_crc, (pos >= 8) ? 8'd0 : b);
        end
        else if (len_ok && (pos - HDR_BYTES) < mdl_len)
        begin
            mdl_crc       = crc_update(mdl_crc, b);
            r             = '0;
            r.kind        = KIND_DATA;
            r.data_byte   = b;
            exp_q.push_back(r);
        end

        // verdict on the first byte at or past the end, so a shrunk length
        // closes the frame straight away
        if (pos + 1 >= flen)
        begin
            r              = '0;
            r.kind         = KIND_VERDICT;
            r.last         = 1'b1;
            r.sequence_res = mdl_seq;
            if (!mdl_magic_ok)
                r.status = ST_BAD_MAGIC;
            else if (!len_ok)
                r.status = ST_LEN_BIG;
            else if ((mdl_crc ^ CRC_ONES) != mdl_rx_crc)
                r.status = ST_CRC_BAD;
            else
                r.status = ST_OK;
            if (r.status == ST_OK || r.status == ST_CRC_BAD)
                r.payload_len = mdl_len[10:0];
            exp_q.push_back(r);
            mdl_in_frame = 1'b0;
            mdl_pos      = '0;
        end
        else
        begin
            mdl_pos = 11'(pos + 1);
        end
    endtask

    // ------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // output checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (exp_q.size() == 0)
            begin
                report_mismatch("unexpected result word", {31'd0, out_ch.kind}, 32'd0);
            end
            else
            begin
                want = exp_q.pop_front();
                if (out_ch.kind !== want.kind)
                    report_mismatch("kind", {31'd0, out_ch.kind}, {31'd0, want.kind});
                if (out_ch.data_byte !== want.data_byte)
                    report_mismatch("data_byte", {24'd0, out_ch.data_byte},
                                    {24'd0, want.data_byte});
                if (out_ch.payload_len !== want.payload_len)
                    report_mismatch("payload_len", {21'd0, out_ch.payload_len},
                                    {21'd0, want.payload_len});
                if (out_ch.sequence_res !== want.sequence_res)
                    report_mismatch("sequence_res", out_ch.sequence_res, want.sequence_res);
                if (out_ch.status !== want.status)
                    report_mismatch("status", {30'd0, out_ch.status}, {30'd0, want.status});
                if (out_ch.last !== want.last)
                    report_mismatch("last", {31'd0, out_ch.last}, {31'd0, want.last});
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : ready_driver
        out_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                // long enough for the result queue and the input side to fill
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (sink_stalls && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // sending side
    // ------------------------------------------------------------------

    // offer one word, wait for the handshake, then run it through the model
    task automatic send_word(input logic [7:0] b, input logic sof);
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.rx_byte     <= b;
        in_ch.frame_start <= sof;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_word(b, sof);
    endtask

    // send frame_buf[first .. upto-1], with the start mark on byte zero
    task automatic send_range(input int unsigned first, input int unsigned upto);
        for (int unsigned k = first; k < upto; k++)
        begin
            send_word(frame_buf[k], k == 0);
        end
    endtask

    // lay out header, payload and padding; crc over header and payload only
    task automatic build_frame(input int unsigned total, input logic [15:0] plen,
                               input logic [31:0] seq_no, input frame_flaw_t flaw);
        logic [31:0] crc;
        logic [8:0]  st;
        logic [16:0] pn;
        int unsigned maxpay;
        int unsigned k;
        maxpay       = total - HDR_BYTES;
        frame_buf[0] = MAGIC0;
        frame_buf[1] = MAGIC1;
        frame_buf[2] = plen[7:0];
        frame_buf[3] = plen[15:8];
        for (k = 0; k < 4; k++)
            frame_buf[4+k] = seq_no[8*k +: 8];
        for (k = HDR_BYTES; k < total; k++)
            frame_buf[k] = 8'($urandom_range(0, 255));

        crc = CRC_ONES;
        for (k = 0; k < 8; k++)
            crc = crc_update(crc, frame_buf[k]);
        for (k = 0; k < 4; k++)
            crc = crc_update(crc, 8'd0);
        if (plen <= maxpay)
        begin
            for (k = 0; k < plen; k++)
                crc = crc_update(crc, frame_buf[HDR_BYTES+k]);
        end
        crc = crc ^ CRC_ONES;
        for (k = 0; k < 4; k++)
            frame_buf[8+k] = crc[8*k +: 8];

        case (flaw)
            FLAW_MAGIC:
            begin
                k = $urandom_range(0, 1);
                frame_buf[k] = frame_buf[k] ^ (8'h01 << $urandom_range(0, 7));
            end
            FLAW_CRC:
            begin
                // hit either the crc field or a payload byte
                if (plen != 0 && plen <= maxpay && $urandom_range(0, 1) == 0)
                    k = HDR_BYTES + $urandom_range(0, plen - 1);
                else
                    k = $urandom_range(8, 11);
                frame_buf[k] = frame_buf[k] ^ (8'h01 << $urandom_range(0, 7));
            end
            default:
            begin
            end
        endcase

        if (cfg_whiten)
        begin
            st = PN_SEED;
            for (k = 0; k < total; k++)
            begin
                pn           = pn9_advance(st);
                st           = pn[16:8];
                frame_buf[k] = frame_buf[k] ^ pn[7:0];
            end
        end
        frame_n = total;
    endtask

    // one whole frame at the current frame length
    task automatic send_frame(input logic [15:0] plen, input logic [31:0] seq_no,
                              input frame_flaw_t flaw);
        build_frame(frame_bytes(cfg_frame_len), plen, seq_no, flaw);
        send_range(0, frame_n);
    endtask

    // stop offering, let every owed result out, then give the pipe time to empty
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (exp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write: setup cycle, access cycle, then the bus is left quiet
    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (idx == REG_FRAME_LEN)
            cfg_frame_len = value[11:0];
        else
            cfg_whiten = value[0];
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values: long frames and no dewhitening, so a clean header's
    // payload comes out unchanged and nothing closes after twenty bytes
    task automatic test_reset_state();
        build_frame(frame_bytes(cfg_frame_len), 16'd5, 32'h1234_5678, FLAW_NONE);
        send_range(0, 20);
    endtask

    // zero frame length clamps to the minimum; whitened frame whose last
    // byte is also its only payload byte, sequence all ones
    task automatic test_whitened_short_frame();
        settle();
        write_reg(REG_FRAME_LEN, 32'd0);
        write_reg(REG_WHITEN, 32'd1);
        send_frame(16'd1, 32'hFFFF_FFFF, FLAW_NONE);
    endtask

    // every verdict code at the minimum length, with stray bytes between frames
    task automatic test_status_codes();
        settle();
        write_reg(REG_FRAME_LEN, {20'd0, MIN_FRAME_BYTES});
        write_reg(REG_WHITEN, 32'd0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_frame(16'd0, 32'd0, FLAW_NONE);
        send_frame(16'd1, 32'hA5A5_5A5A, FLAW_MAGIC);
        send_frame(16'hFFFF, $urandom, FLAW_NONE);
        send_frame(16'd1, $urandom, FLAW_CRC);
    endtask

    // a start in mid-frame throws the old frame away
    task automatic test_cut_frame();
        settle();
        write_reg(REG_FRAME_LEN, 32'd20);
        build_frame(20, 16'd6, $urandom, FLAW_NONE);
        send_range(0, 7);
        send_frame(16'd8, $urandom, FLAW_NONE);
    endtask

    // length shrunk and whitening switched while a frame is half way through
    task automatic test_mid_frame_changes();
        settle();
        write_reg(REG_FRAME_LEN, 32'd40);
        build_frame(40, 16'd20, $urandom, FLAW_NONE);
        send_range(0, 16);
        settle();
        // verdict is due on the very next byte; the rest falls outside a frame
        write_reg(REG_FRAME_LEN, 32'd14);
        send_range(16, 20);

        settle();
        write_reg(REG_FRAME_LEN, 32'd30);
        build_frame(30, 16'd10, $urandom, FLAW_NONE);
        send_range(0, 14);
        settle();
        write_reg(REG_WHITEN, 32'd1);
        send_range(14, frame_n);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        settle();
        write_reg(REG_FRAME_LEN, 32'd60);
        write_reg(REG_WHITEN, 32'd0);
        hold_req = 1'b1;
        send_frame(16'd48, $urandom, FLAW_NONE);
    endtask

    // all-ones length register clamps to the largest frame: a header length
    // one past what that frame holds lets no payload out, the largest fits;
    // both frames are left open and dropped by the next start
    task automatic test_largest_frame();
        int unsigned maxpay;
        settle();
        write_reg(REG_FRAME_LEN, 32'h0000_0FFF);
        write_reg(REG_WHITEN, 32'd1);
        maxpay = frame_bytes(cfg_frame_len) - HDR_BYTES;
        build_frame(frame_bytes(cfg_frame_len), 16'(maxpay + 1), $urandom, FLAW_NONE);
        send_range(0, 24);
        build_frame(frame_bytes(cfg_frame_len), 16'(maxpay), $urandom, FLAW_NONE);
        send_range(0, 24);
    endtask

    // mostly well-formed frames with random content, the rest flawed,
    // cut short, or plain noise; settings change between phases
    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned pick;
        int unsigned maxpay;
        int unsigned flen_val;
        int unsigned nwords;
        logic [15:0] plen;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            settle();
            pick = $urandom_range(0, 99);
            if (pick < 75)
                flen_val = $urandom_range(13, 48);
            else if (pick < 85)
                flen_val = $urandom_range(0, 12);
            else
                flen_val = $urandom_range(49, 200);
            // upper bits of the bus carry junk the register must ignore
            write_reg(REG_FRAME_LEN, ($urandom & 32'hFFFF_F000) | flen_val);
            write_reg(REG_WHITEN, ($urandom & 32'hFFFF_FFFE) | $urandom_range(0, 1));

            repeat ($urandom_range(1, 4))
            begin
                maxpay = frame_bytes(cfg_frame_len) - HDR_BYTES;
                pick   = $urandom_range(0, 99);
                case ($urandom_range(0, 3))
                    0:       plen = 16'd0;
                    1:       plen = 16'(maxpay);
                    default: plen = 16'($urandom_range(0, maxpay));
                endcase
                if (pick < 55)
                begin
                    send_frame(plen, $urandom, FLAW_NONE);
                    sent += frame_n;
                end
                else if (pick < 65)
                begin
                    send_frame(plen, $urandom, FLAW_MAGIC);
                    sent += frame_n;
                end
                else if (pick < 75)
                begin
                    send_frame(plen, $urandom, FLAW_CRC);
                    sent += frame_n;
                end
                else if (pick < 83)
                begin
                    send_frame(16'($urandom_range(maxpay + 1, 65535)), $urandom, FLAW_NONE);
                    sent += frame_n;
                end
                else if (pick < 90)
                begin
                    // left open: the next start, or the next phase, deals with it
                    build_frame(frame_bytes(cfg_frame_len), plen, $urandom, FLAW_NONE);
                    nwords = $urandom_range(1, frame_n - 1);
                    send_range(0, nwords);
                    sent += nwords;
                end
                else if (pick < 96)
                begin
                    repeat ($urandom_range(1, 4))
                        send_word(8'($urandom_range(0, 255)), 1'b0);
                end
                else
                begin
                    nwords = $urandom_range(5, 30);
                    repeat (nwords)
                        send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                    sent += nwords;
                end
            end
        end
    endtask

    // back-to-back words and an always-ready receiver to close the run
    task automatic test_steady_stream();
        settle();
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        write_reg(REG_FRAME_LEN, 32'd24);
        write_reg(REG_WHITEN, 32'd1);
        repeat (4)
            send_frame(16'($urandom_range(0, 12)), $urandom, FLAW_NONE);
        send_frame(16'd12, $urandom, FLAW_CRC);
        send_frame(16'd3, $urandom, FLAW_MAGIC);
    endtask

    // ------------------------------------------------------------------
    // timeout
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int wait_cycles;
        errors            = 0;
        src_gaps          = 1'b1;
        sink_stalls       = 1'b1;
        hold_req          = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.rx_byte     = '0;
        in_ch.frame_start = 1'b0;

        // shadow and model start from the reset values
        cfg_frame_len = 12'd1516;
        cfg_whiten    = 1'b0;
        mdl_pos       = '0;
        mdl_lfsr      = PN_SEED;
        mdl_crc       = CRC_ONES;
        mdl_len       = '0;
        mdl_seq       = '0;
        mdl_rx_crc    = '0;
        mdl_magic_ok  = 1'b0;
        mdl_in_frame  = 1'b0;

        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_whitened_short_frame();
        test_status_codes();
        test_cut_frame();
        test_mid_frame_changes();
        test_backpressure();
        test_random_traffic();
        test_largest_frame();
        test_steady_stream();

        // drain what is still owed, bounded, then let the pipe empty
        in_ch.valid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < DRAIN_LIMIT && exp_q.size() != 0; wait_cycles++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (exp_q.size() != 0)
            report_mismatch("results never delivered", exp_q.size(), 32'd0);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
